/* design/jsc_pkg.sv */
// Shared types and constants for the JSON structure checker.
// Token codes, stack sizing, register map and the result item type.
// No dependencies; the interfaces and the checker refer to this package.
package jsc_pkg;

   // Depth of the open-container stack.
   localparam int STACK_DEPTH = 64;

   // Width of the open-level counter, which must hold STACK_DEPTH itself.
   localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
   // Address width of the stack memory.
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // Field widths of the items.
   localparam int TOKEN_W = 4;
   localparam int LEVELS_W = 7;
   localparam int MAX_NEST_W = 7;

   // Width used to compare the level counter with the nesting limit.
   localparam int CMP_W = (LEVEL_W > MAX_NEST_W) ? LEVEL_W : MAX_NEST_W;

   // Token kinds.
   localparam logic [TOKEN_W-1:0] TOK_LBRACE   = 4'd0;
   localparam logic [TOKEN_W-1:0] TOK_RBRACE   = 4'd1;
   localparam logic [TOKEN_W-1:0] TOK_LBRACKET = 4'd2;
   localparam logic [TOKEN_W-1:0] TOK_RBRACKET = 4'd3;
   localparam logic [TOKEN_W-1:0] TOK_COLON    = 4'd4;
   localparam logic [TOKEN_W-1:0] TOK_COMMA    = 4'd5;
   localparam logic [TOKEN_W-1:0] TOK_STRING   = 4'd6;
   localparam logic [TOKEN_W-1:0] TOK_NUMBER   = 4'd7;
   localparam logic [TOKEN_W-1:0] TOK_TRUE     = 4'd8;
   localparam logic [TOKEN_W-1:0] TOK_FALSE    = 4'd9;
   localparam logic [TOKEN_W-1:0] TOK_NULL     = 4'd10;

   // Register map: one 32-bit register every four bytes.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_LSB = 2;
   localparam logic CSR_IDX_MAX_NESTING = 1'b0;
   localparam logic CSR_IDX_TRAIL_COMMA = 1'b1;

   // Reset value of the nesting limit register.
   localparam logic [MAX_NEST_W-1:0] MAX_NEST_RESET = 7'd64;

   // One result item.
   typedef struct packed {
      logic                accepted;
      logic                complete;
      logic [LEVELS_W-1:0] open_levels;
      logic                too_deep;
   } rsp_type;

endpackage

/* design/jsc_if.sv */
// Channel interfaces of the JSON structure checker: token items in, result items out.
// Depends on jsc_pkg for the field widths.

interface jsc_req_if;
   logic                        valid;
   logic                        ready;
   logic [jsc_pkg::TOKEN_W-1:0] token_kind;

   modport source(output valid, output token_kind, input ready);
   modport sink(input valid, input token_kind, output ready);
endinterface

interface jsc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         accepted;
   logic                         complete;
   logic [jsc_pkg::LEVELS_W-1:0] open_levels;
   logic                         too_deep;

   modport source(output valid, output accepted, output complete,
                  output open_levels, output too_deep, input ready);
   modport sink(input valid, input accepted, input complete,
                input open_levels, input too_deep, output ready);
endinterface

/* design/jsc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the container stack of the JSON structure checker.
module jsc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/json_structure_checker.sv */
// JSON structure checker: one token item in, one result item out, decided combinationally.
// The result item is registered in the main output register, or in the skid one if stalled.
// One token per cycle unless stalled; a two-entry buffer keeps input and output apart.
// Reset (synchronous, active high) empties the buffer, clears the level count, the done
// flag and the expectation state, and loads the register reset values. The stack memory
// is not cleared: an entry is always pushed before it is read back.
module json_structure_checker (
   input  logic                              clock,
   input  logic                              reset,
   jsc_req_if.sink                           req_ch,
   jsc_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [jsc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [jsc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [jsc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   // What the parser expects next. Codes six and seven are never reached; in them
   // every token is rejected.
   typedef enum logic [2:0] {
      ST_VALUE     = 3'd0,   // a value; at level zero only an opening brace or bracket
      ST_NEXT      = 3'd1,   // a comma or a closing brace or bracket
      ST_OBJ_FIRST = 3'd2,   // the first key or a closing brace
      ST_OBJ_KEY   = 3'd3,   // a key after a comma
      ST_COLON     = 3'd4,   // a colon after a key
      ST_ARR_FIRST = 3'd5    // the first value or a closing bracket
   } expect_type;

   // ---------------------------------------------------------------------------------
   // State registers
   // ---------------------------------------------------------------------------------
   expect_type                          state_ff,      state_in;
   logic [jsc_pkg::LEVEL_W-1:0]         level_ff,      level_in;
   logic                                done_ff,       done_in;
   // The kind of the innermost open container (1 = object) lives in a flop; the
   // memory holds the kinds of all containers below it.
   logic                                top_ff,        top_in;
   logic                                byp_ff,        byp_in;
   logic                                byp_dat_ff,    byp_dat_in;
   logic [jsc_pkg::MAX_NEST_W-1:0]      max_nest_ff;
   logic                                trail_ff;

   // Output buffer: the main register drives the port, the skid register catches one
   // item that arrives while the main one is stalled.
   jsc_pkg::rsp_type                    main_ff,       main_in;
   logic                                main_vld_ff,   main_vld_in;
   jsc_pkg::rsp_type                    skid_ff,       skid_in;
   logic                                skid_vld_ff,   skid_vld_in;

   // ---------------------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------------------
   logic accept;
   logic out_fire;

   assign req_ch.ready = !skid_vld_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_fire     = rsp_ch.valid && rsp_ch.ready;

   // ---------------------------------------------------------------------------------
   // Stack memory. Each cycle it reads the entry that sits just below the next top,
   // so that a pop in the following cycle finds the new top kind ready. A push that
   // writes the very entry being read is forwarded through the bypass flop.
   // ---------------------------------------------------------------------------------
   logic                                ram_we;
   logic [jsc_pkg::ADDR_W-1:0]          ram_waddr;
   logic [jsc_pkg::ADDR_W-1:0]          ram_raddr;
   logic                                ram_rdata;
   logic                                below_kind;

   assign ram_waddr  = jsc_pkg::ADDR_W'(level_ff - jsc_pkg::LEVEL_W'(1));
   assign ram_raddr  = jsc_pkg::ADDR_W'(level_in - jsc_pkg::LEVEL_W'(2));
   assign byp_in     = ram_we && (ram_waddr == ram_raddr);
   assign byp_dat_in = top_ff;
   assign below_kind = byp_ff ? byp_dat_ff : ram_rdata;

   jsc_ram #(
      .WIDTH(1),
      .DEPTH(jsc_pkg::STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(top_ff),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // ---------------------------------------------------------------------------------
   // Token decision
   // ---------------------------------------------------------------------------------
   logic [jsc_pkg::TOKEN_W-1:0] tok;
   logic [jsc_pkg::CMP_W-1:0]   limit;
   logic                        is_open;
   logic                        is_scalar;
   logic                        want_value;
   logic                        has_level;
   logic                        obj_top;
   logic                        at_limit;
   logic                        ok;
   logic                        deep;
   logic                        push;
   logic                        pop;
   logic                        close_ok;
   expect_type                  st_ok;

   assign tok = req_ch.token_kind;

   // The effective nesting limit is the register clamped to one up to the stack depth.
   always_comb begin
      if (max_nest_ff == '0) begin
         limit = jsc_pkg::CMP_W'(1);
      end else if (jsc_pkg::CMP_W'(max_nest_ff) > jsc_pkg::CMP_W'(jsc_pkg::STACK_DEPTH)) begin
         limit = jsc_pkg::CMP_W'(jsc_pkg::STACK_DEPTH);
      end else begin
         limit = jsc_pkg::CMP_W'(max_nest_ff);
      end
   end

   assign is_open    = (tok == jsc_pkg::TOK_LBRACE) || (tok == jsc_pkg::TOK_LBRACKET);
   assign is_scalar  = (tok == jsc_pkg::TOK_STRING) || (tok == jsc_pkg::TOK_NUMBER) ||
                       (tok == jsc_pkg::TOK_TRUE)   || (tok == jsc_pkg::TOK_FALSE)  ||
                       (tok == jsc_pkg::TOK_NULL);
   assign want_value = (state_ff == ST_VALUE) || (state_ff == ST_ARR_FIRST);
   assign has_level  = (level_ff != '0);
   assign obj_top    = has_level && top_ff;
   assign at_limit   = (jsc_pkg::CMP_W'(level_ff) >= limit);

   always_comb begin
      ok       = 1'b0;
      deep     = 1'b0;
      push     = 1'b0;
      pop      = 1'b0;
      close_ok = 1'b0;
      st_ok    = state_ff;
      if (!done_ff) begin
         if (is_open && want_value) begin
            if (at_limit) begin
               deep = 1'b1;
            end else begin
               push  = 1'b1;
               ok    = 1'b1;
               st_ok = (tok == jsc_pkg::TOK_LBRACE) ? ST_OBJ_FIRST : ST_ARR_FIRST;
            end
         end else if (is_scalar && want_value && has_level) begin
            ok    = 1'b1;
            st_ok = ST_NEXT;
         end else if ((tok == jsc_pkg::TOK_STRING) &&
                      ((state_ff == ST_OBJ_FIRST) || (state_ff == ST_OBJ_KEY))) begin
            ok    = 1'b1;
            st_ok = ST_COLON;
         end else if ((tok == jsc_pkg::TOK_COLON) && (state_ff == ST_COLON)) begin
            ok    = 1'b1;
            st_ok = ST_VALUE;
         end else if ((tok == jsc_pkg::TOK_COMMA) && (state_ff == ST_NEXT)) begin
            ok    = 1'b1;
            st_ok = obj_top ? ST_OBJ_KEY : ST_VALUE;
         end else if (tok == jsc_pkg::TOK_RBRACE) begin
            // A brace closes an empty object, an object after a member, or, when
            // trailing commas are allowed, an object right after a comma.
            close_ok = (state_ff == ST_OBJ_FIRST) || ((state_ff == ST_NEXT) && obj_top) ||
                       ((state_ff == ST_OBJ_KEY) && trail_ff);
         end else if (tok == jsc_pkg::TOK_RBRACKET) begin
            close_ok = (state_ff == ST_ARR_FIRST) ||
                       ((state_ff == ST_NEXT) && !obj_top && has_level);
         end
         if (close_ok && has_level) begin
            pop   = 1'b1;
            ok    = 1'b1;
            st_ok = ST_NEXT;
         end
      end
   end

   // Next state: only an accepted token that was taken changes anything.
   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      done_in  = done_ff;
      top_in   = top_ff;
      ram_we   = 1'b0;
      if (accept && ok) begin
         state_in = st_ok;
         if (push) begin
            level_in = level_ff + jsc_pkg::LEVEL_W'(1);
            top_in   = (tok == jsc_pkg::TOK_LBRACE);
            ram_we   = has_level;
         end else if (pop) begin
            level_in = level_ff - jsc_pkg::LEVEL_W'(1);
            top_in   = below_kind;
            done_in  = (level_ff == jsc_pkg::LEVEL_W'(1));
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Output buffer
   // ---------------------------------------------------------------------------------
   jsc_pkg::rsp_type new_rsp;

   assign new_rsp.accepted    = ok;
   assign new_rsp.complete    = done_in;
   assign new_rsp.open_levels = jsc_pkg::LEVELS_W'(level_in);
   assign new_rsp.too_deep    = deep;

   always_comb begin
      main_in     = main_ff;
      main_vld_in = main_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (out_fire || !main_vld_ff) begin
         if (skid_vld_ff) begin
            main_in     = skid_ff;
            main_vld_in = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            main_in     = new_rsp;
            main_vld_in = accept;
         end
      end else if (accept) begin
         skid_in     = new_rsp;
         skid_vld_in = 1'b1;
      end
   end

   assign rsp_ch.valid       = main_vld_ff;
   assign rsp_ch.accepted    = main_ff.accepted;
   assign rsp_ch.complete    = main_ff.complete;
   assign rsp_ch.open_levels = main_ff.open_levels;
   assign rsp_ch.too_deep    = main_ff.too_deep;

   // ---------------------------------------------------------------------------------
   // Configuration port. Registers must be written only when the block is idle; unchecked.
   // ---------------------------------------------------------------------------------
   logic csr_wr;
   logic csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[jsc_pkg::CSR_IDX_LSB];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_idx)
         jsc_pkg::CSR_IDX_MAX_NESTING: csr_prdata = jsc_pkg::CSR_DATA_W'(max_nest_ff);
         jsc_pkg::CSR_IDX_TRAIL_COMMA: csr_prdata = jsc_pkg::CSR_DATA_W'(trail_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // All registers of the top level.
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_VALUE;
         level_ff    <= '0;
         done_ff     <= 1'b0;
         top_ff      <= 1'b0;
         byp_ff      <= 1'b0;
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
         max_nest_ff <= jsc_pkg::MAX_NEST_RESET;
         trail_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         level_ff    <= level_in;
         done_ff     <= done_in;
         top_ff      <= top_in;
         byp_ff      <= byp_in;
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
         if (csr_wr && (csr_idx == jsc_pkg::CSR_IDX_MAX_NESTING)) begin
            max_nest_ff <= csr_pwdata[jsc_pkg::MAX_NEST_W-1:0];
         end
         if (csr_wr && (csr_idx == jsc_pkg::CSR_IDX_TRAIL_COMMA)) begin
            trail_ff <= csr_pwdata[0];
         end
      end
      byp_dat_ff <= byp_dat_in;
      main_ff    <= main_in;
      skid_ff    <= skid_in;
   end

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------

   // The open-level count never passes the stack depth.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      jsc_pkg::CMP_W'(level_ff) <= jsc_pkg::CMP_W'(jsc_pkg::STACK_DEPTH))
      else $error("level count beyond stack depth");

   // A finished document has no open container left.
   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (level_ff == '0) && (state_ff == ST_NEXT))
      else $error("document complete with containers still open");

   // The skid entry is only ever filled behind a waiting main entry.
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> main_vld_ff)
      else $error("skid entry holds an item while the output register is empty");

   // An accepted opening token raises the level by exactly one.
   a_push_level: assert property (@(posedge clock) disable iff (reset)
      (accept && ok && push) |=> (level_ff == $past(level_ff) + jsc_pkg::LEVEL_W'(1)))
      else $error("push did not raise the level by one");

endmodule

/* tb/json_structure_checker_tb.sv */
// Self-checking testbench for the JSON structure checker: token items in, result items out.
// A scoreboard class predicts every result from its own copy of the parser state.
// Depends on jsc_pkg, the jsc_req_if and jsc_rsp_if interfaces and the checker itself.

// Expectation states of the structure parser, in the block's own encoding.
typedef enum logic [2:0] {
   WANT_VALUE      = 3'd0,
   WANT_NEXT       = 3'd1,
   WANT_FIRST_KEY  = 3'd2,
   WANT_KEY        = 3'd3,
   WANT_COLON      = 3'd4,
   WANT_FIRST_ITEM = 3'd5
} parse_state_type;

module json_structure_checker_tb;

   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 8;
   localparam int TIMEOUT_CYCLES = 300000;
   localparam int ITEMS_PER_SEGMENT = 170;
   localparam int SEGMENTS = 6;
   localparam int NOISE_PCT = 15;

   // Codes 11 to 15 are not tokens at all; the block must reject them.
   localparam logic [jsc_pkg::TOKEN_W-1:0] TOK_INVALID_FIRST = 4'd11;
   localparam logic [jsc_pkg::TOKEN_W-1:0] TOK_INVALID_LAST  = 4'd15;

   // The scoreboard carries a full copy of the parser: the container stack, the
   // open level count, the expectation state, the completion flag and both
   // registers. Every accepted token item is run through it at once, and the
   // predicted result item waits in a queue until the block delivers its own.
   class structure_scoreboard;
      typedef struct {
         logic [jsc_pkg::TOKEN_W-1:0] token;
         jsc_pkg::rsp_type            result;
      } predicted_result_type;

      bit                             container_is_object[jsc_pkg::STACK_DEPTH];
      int                             depth_count;
      parse_state_type                parse_state;
      bit                             doc_closed;
      logic [jsc_pkg::MAX_NEST_W-1:0] nest_limit_reg;
      bit                             trailing_comma_ok;
      predicted_result_type           pending_results[$];
      int                             errors;

      function new();
         depth_count = 0;
         parse_state = WANT_VALUE;
         doc_closed = 0;
         nest_limit_reg = jsc_pkg::MAX_NEST_RESET;
         trailing_comma_ok = 0;
         errors = 0;
      endfunction

      function void write_register(logic idx, logic [jsc_pkg::CSR_DATA_W-1:0] value);
         if (idx == jsc_pkg::CSR_IDX_MAX_NESTING) begin
            nest_limit_reg = value[jsc_pkg::MAX_NEST_W-1:0];
         end else begin
            trailing_comma_ok = value[0];
         end
      endfunction

      // A limit of zero behaves as one, and anything above the stack depth as the depth.
      function int current_limit();
         int lim;
         lim = nest_limit_reg;
         if (lim < 1) lim = 1;
         if (lim > jsc_pkg::STACK_DEPTH) lim = jsc_pkg::STACK_DEPTH;
         return lim;
      endfunction

      // Works out the result of one token. With commit low it only looks ahead,
      // which lets the stimulus side ask what a token would do.
      function jsc_pkg::rsp_type evaluate(logic [jsc_pkg::TOKEN_W-1:0] tok, bit commit);
         jsc_pkg::rsp_type r;
         bit               ok;
         bit               deep;
         bit               obj_top;
         bit               want_value;
         bit               is_open;
         bit               is_scalar;
         bit               close_ok;
         bit               closed;
         int               lvl;
         parse_state_type  nxt;
         lvl = depth_count;
         nxt = parse_state;
         closed = doc_closed;
         ok = 0;
         deep = 0;
         is_open = (tok == jsc_pkg::TOK_LBRACE) || (tok == jsc_pkg::TOK_LBRACKET);
         is_scalar = (tok >= jsc_pkg::TOK_STRING) && (tok <= jsc_pkg::TOK_NULL);
         obj_top = (lvl > 0) ? container_is_object[lvl-1] : 1'b0;
         want_value = (parse_state == WANT_VALUE) || (parse_state == WANT_FIRST_ITEM);
         if (!closed) begin
            if (is_open && want_value) begin
               if (lvl >= current_limit()) begin
                  deep = 1;
               end else begin
                  if (commit) container_is_object[lvl] = (tok == jsc_pkg::TOK_LBRACE);
                  lvl++;
                  nxt = (tok == jsc_pkg::TOK_LBRACE) ? WANT_FIRST_KEY : WANT_FIRST_ITEM;
                  ok = 1;
               end
            end else if (is_scalar && want_value && lvl > 0) begin
               nxt = WANT_NEXT;
               ok = 1;
            end else if (tok == jsc_pkg::TOK_STRING &&
                         (parse_state == WANT_FIRST_KEY || parse_state == WANT_KEY)) begin
               nxt = WANT_COLON;
               ok = 1;
            end else if (tok == jsc_pkg::TOK_COLON && parse_state == WANT_COLON) begin
               nxt = WANT_VALUE;
               ok = 1;
            end else if (tok == jsc_pkg::TOK_COMMA && parse_state == WANT_NEXT) begin
               nxt = obj_top ? WANT_KEY : WANT_VALUE;
               ok = 1;
            end else if (tok == jsc_pkg::TOK_RBRACE || tok == jsc_pkg::TOK_RBRACKET) begin
               if (tok == jsc_pkg::TOK_RBRACE) begin
                  close_ok = (parse_state == WANT_FIRST_KEY) ||
                             (parse_state == WANT_NEXT && obj_top) ||
                             (parse_state == WANT_KEY && trailing_comma_ok);
               end else begin
                  close_ok = (parse_state == WANT_FIRST_ITEM) ||
                             (parse_state == WANT_NEXT && !obj_top && lvl > 0);
               end
               if (close_ok && lvl > 0) begin
                  lvl--;
                  if (lvl == 0) closed = 1;
                  nxt = WANT_NEXT;
                  ok = 1;
               end
            end
         end
         if (commit) begin
            depth_count = lvl;
            parse_state = nxt;
            doc_closed = closed;
         end
         r.accepted = ok;
         r.complete = closed;
         r.open_levels = lvl[jsc_pkg::LEVELS_W-1:0];
         r.too_deep = deep;
         return r;
      endfunction

      function void note_token(logic [jsc_pkg::TOKEN_W-1:0] tok);
         predicted_result_type p;
         p.token = tok;
         p.result = evaluate(tok, 1);
         pending_results.push_back(p);
      endfunction

      function int tokens_waiting();
         return pending_results.size();
      endfunction

      function void compare_field(string field_name, logic [jsc_pkg::TOKEN_W-1:0] tok,
                                  int want, int got);
         if (want != got) begin
            $display("%0t: token %0d, %s expected %0d actual %0d",
                     $time, tok, field_name, want, got);
            errors++;
         end
      endfunction

      function void check_result(jsc_pkg::rsp_type seen);
         predicted_result_type p;
         if (pending_results.size() == 0) begin
            $display("%0t: result with no token waiting, expected none actual %b",
                     $time, seen);
            errors++;
            return;
         end
         p = pending_results.pop_front();
         compare_field("accepted", p.token, p.result.accepted, seen.accepted);
         compare_field("complete", p.token, p.result.complete, seen.complete);
         compare_field("open_levels", p.token, p.result.open_levels, seen.open_levels);
         compare_field("too_deep", p.token, p.result.too_deep, seen.too_deep);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   jsc_req_if req_ch();
   jsc_rsp_if rsp_ch();

   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [jsc_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [jsc_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [jsc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   structure_scoreboard sb;

   // Idle percentages of the two sides, changed by the main sequence per phase.
   int send_idle_pct;
   int recv_idle_pct;

   // Nesting depth the random stream is steering toward at the moment.
   int depth_goal;

   json_structure_checker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Presents one token item, with random idle cycles first, and returns in the
   // time step of the clock edge that accepted it. Valid stays high on return, so
   // a following call can keep the stream going without a gap. The prediction is
   // made at the accepting edge, so the parser copy is current for the next pick.
   task automatic send_token(input logic [jsc_pkg::TOKEN_W-1:0] tok);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.token_kind <= tok;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_token(tok);
   endtask

   // Register write: setup, then access until pready, then idle so that
   // two writes never touch the bus signals in the same time step.
   task automatic csr_write(input logic idx, input logic [jsc_pkg::CSR_DATA_W-1:0] value);
      logic [jsc_pkg::CSR_ADDR_W-1:0] addr;
      addr = jsc_pkg::CSR_ADDR_W'(idx) << jsc_pkg::CSR_IDX_LSB;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_register(idx, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Lowers valid in the step of the last acceptance, then waits until every
   // predicted result has come back and the output buffer has settled.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (sb.tokens_waiting() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Picks the next token. Most of the stream follows the grammar, so the parser
   // keeps moving through nested objects and arrays; the rest is random noise.
   // The outermost container is never closed until the finishing pass, because
   // a completed document rejects everything that follows and reset is not
   // asserted again.
   function automatic logic [jsc_pkg::TOKEN_W-1:0] next_token(bit finishing);
      logic [jsc_pkg::TOKEN_W-1:0] tok;
      jsc_pkg::rsp_type            peek;
      int                          lvl;
      int                          goal;
      bit                          obj_top;
      bit                          may_close;
      lvl = sb.depth_count;
      obj_top = (lvl > 0) && sb.container_is_object[lvl-1];
      may_close = finishing || lvl > 1;
      if (!finishing && $urandom_range(99) < NOISE_PCT) begin
         tok = jsc_pkg::TOKEN_W'($urandom_range(TOK_INVALID_LAST));
         peek = sb.evaluate(tok, 0);
         // Noise that would finish the document is swapped for a non-token.
         if (peek.complete) begin
            tok = jsc_pkg::TOKEN_W'($urandom_range(TOK_INVALID_LAST, TOK_INVALID_FIRST));
         end
         return tok;
      end
      if (!finishing && (lvl == depth_goal || $urandom_range(39) == 0)) begin
         // Mostly shallow documents, now and then a dive to the stack limit and past it.
         depth_goal = ($urandom_range(9) < 7) ? $urandom_range(8, 1) :
                                                $urandom_range(jsc_pkg::STACK_DEPTH + 2, 8);
      end
      goal = finishing ? 0 : depth_goal;
      case (sb.parse_state)
         WANT_VALUE, WANT_FIRST_ITEM: begin
            if (sb.parse_state == WANT_FIRST_ITEM && may_close &&
                (lvl > goal || $urandom_range(5) == 0)) begin
               tok = jsc_pkg::TOK_RBRACKET;
            end else if (lvl < goal &&
                         (lvl < sb.current_limit() || $urandom_range(3) == 0)) begin
               tok = $urandom_range(1) ? jsc_pkg::TOK_LBRACE : jsc_pkg::TOK_LBRACKET;
            end else begin
               tok = jsc_pkg::TOKEN_W'($urandom_range(jsc_pkg::TOK_NULL, jsc_pkg::TOK_STRING));
            end
         end
         WANT_NEXT: begin
            if (may_close && (lvl > goal || $urandom_range(4) == 0)) begin
               tok = obj_top ? jsc_pkg::TOK_RBRACE : jsc_pkg::TOK_RBRACKET;
            end else begin
               tok = jsc_pkg::TOK_COMMA;
            end
         end
         WANT_FIRST_KEY: begin
            if (may_close && (lvl > goal || $urandom_range(3) == 0)) begin
               tok = jsc_pkg::TOK_RBRACE;
            end else begin
               tok = jsc_pkg::TOK_STRING;
            end
         end
         WANT_KEY: begin
            // A trailing comma before the brace is only tried where it is legal.
            if (may_close && sb.trailing_comma_ok && $urandom_range(3) == 0) begin
               tok = jsc_pkg::TOK_RBRACE;
            end else begin
               tok = jsc_pkg::TOK_STRING;
            end
         end
         WANT_COLON: tok = jsc_pkg::TOK_COLON;
         default: tok = jsc_pkg::TOKEN_W'($urandom_range(TOK_INVALID_LAST));
      endcase
      return tok;
   endfunction

   // Receiver: checks every result item taken and stalls at random.
   initial begin
      jsc_pkg::rsp_type observed;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            observed.accepted = rsp_ch.accepted;
            observed.complete = rsp_ch.complete;
            observed.open_levels = rsp_ch.open_levels;
            observed.too_deep = rsp_ch.too_deep;
            sb.check_result(observed);
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Main sequence: reset, a directed opening, six random segments under
   // different register settings and idle patterns, then the document is closed
   // and every token code is sent once more to see it rejected.
   initial begin
      sb = new();
      send_idle_pct = 27;
      recv_idle_pct = 62;
      depth_goal = 4;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.token_kind <= jsc_pkg::TOK_LBRACE;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Before the first container nothing but an opener is taken: non-tokens,
      // punctuation, closers and bare scalars are all rejected at level zero.
      send_token(TOK_INVALID_FIRST);
      send_token(TOK_INVALID_LAST);
      send_token(jsc_pkg::TOK_COLON);
      send_token(jsc_pkg::TOK_COMMA);
      send_token(jsc_pkg::TOK_RBRACE);
      send_token(jsc_pkg::TOK_RBRACKET);
      send_token(jsc_pkg::TOK_STRING);
      send_token(jsc_pkg::TOK_NUMBER);
      // Open the outer object, then try an array where a key belongs.
      send_token(jsc_pkg::TOK_LBRACE);
      send_token(jsc_pkg::TOK_LBRACKET);
      // "k": [] , then a trailing comma before the brace, which is off after reset.
      send_token(jsc_pkg::TOK_STRING);
      send_token(jsc_pkg::TOK_COLON);
      send_token(jsc_pkg::TOK_LBRACKET);
      send_token(jsc_pkg::TOK_RBRACKET);
      send_token(jsc_pkg::TOK_COMMA);
      send_token(jsc_pkg::TOK_RBRACE);
      // "k": [ 1 , ]  - a trailing comma in an array is always refused.
      send_token(jsc_pkg::TOK_STRING);
      send_token(jsc_pkg::TOK_COLON);
      send_token(jsc_pkg::TOK_LBRACKET);
      send_token(jsc_pkg::TOK_NUMBER);
      send_token(jsc_pkg::TOK_COMMA);
      send_token(jsc_pkg::TOK_RBRACKET);
      // Finish the array with null, but first try to close it with a brace.
      send_token(jsc_pkg::TOK_NULL);
      send_token(jsc_pkg::TOK_RBRACE);
      send_token(jsc_pkg::TOK_RBRACKET);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         // The first two segments keep the opening idle pattern; the middle two
         // swap it, and the last two run with neither side idling.
         if (seg == 2) begin
            send_idle_pct = 62;
            recv_idle_pct = 27;
         end else if (seg == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // The first segment runs on the reset values of both registers.
         if (seg != 0) begin
            drain_results();
            case (seg)
               1: begin
                  csr_write(jsc_pkg::CSR_IDX_MAX_NESTING, 32'd1);
                  csr_write(jsc_pkg::CSR_IDX_TRAIL_COMMA, 32'd1);
               end
               2: begin
                  csr_write(jsc_pkg::CSR_IDX_MAX_NESTING, 32'd127);
                  csr_write(jsc_pkg::CSR_IDX_TRAIL_COMMA, 32'd0);
               end
               3: begin
                  csr_write(jsc_pkg::CSR_IDX_MAX_NESTING, 32'd0);
                  csr_write(jsc_pkg::CSR_IDX_TRAIL_COMMA, 32'd1);
               end
               4: begin
                  csr_write(jsc_pkg::CSR_IDX_MAX_NESTING,
                            $urandom_range(jsc_pkg::STACK_DEPTH - 1, 2));
                  csr_write(jsc_pkg::CSR_IDX_TRAIL_COMMA, $urandom_range(1));
               end
               default: begin
                  csr_write(jsc_pkg::CSR_IDX_MAX_NESTING, jsc_pkg::STACK_DEPTH);
                  csr_write(jsc_pkg::CSR_IDX_TRAIL_COMMA, 32'd1);
               end
            endcase
         end
         repeat (ITEMS_PER_SEGMENT) send_token(next_token(1'b0));
      end

      // Walk the stack back down along the grammar until the outermost closes.
      while (!sb.doc_closed) send_token(next_token(1'b1));
      // A finished document takes nothing further.
      for (int t = 0; t <= TOK_INVALID_LAST; t++) send_token(t[jsc_pkg::TOKEN_W-1:0]);

      drain_results();
      if (sb.errors == 0 && sb.tokens_waiting() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
